>>> rtl/gwwm_pkg.sv
// Shared types, codes and widths for the greedy word wrap measurer.
`timescale 1ns / 1ps

package gwwm_pkg;

    // Default accumulator and line counter widths.
    localparam int ACC_BITS_DEFAULT  = 32;
    localparam int LINE_BITS_DEFAULT = 16;

    // Fixed field widths of the ports.
    localparam int ADV_BITS       = 16;
    localparam int KERN_BITS      = 16;
    localparam int WIDTH_BITS     = 31;
    localparam int COUNT_BITS     = 16;
    localparam int SPACE_BITS     = 16;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = 31'h7FFF_FFFF;

    // Item kinds.
    localparam logic MODE_CODE = 1'b0;
    localparam logic MODE_END  = 1'b1;

    // Character classes.
    localparam logic [1:0] CLASS_GLYPH   = 2'd0;
    localparam logic [1:0] CLASS_SPACE   = 2'd1;
    localparam logic [1:0] CLASS_TAB     = 2'd2;
    localparam logic [1:0] CLASS_NEWLINE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WRAP_LIMIT    = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPACE_ADVANCE = 4'd1;

    typedef struct packed {
        logic                        mode;
        logic [1:0]                  char_class;
        logic [ADV_BITS-1:0]         advance;
        logic signed [KERN_BITS-1:0] kern_adjust;
    } item_t;

    typedef struct packed {
        logic [WIDTH_BITS-1:0] text_width;
        logic [COUNT_BITS-1:0] line_count;
    } result_t;

endpackage

>>> rtl/gwwm_in_stage.sv
// Input register stage holding one word ahead of the measuring core.
`timescale 1ns / 1ps

module gwwm_in_stage
    import gwwm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    output logic  up_ready,
    input  item_t up_item,
    output logic  down_valid,
    input  logic  down_ready,
    output item_t down_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign up_ready = !valid_reg || down_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (up_valid && up_ready)
        begin
            valid_next = 1'b1;
        end
        else if (down_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            item_reg <= up_item;
        end
    end

    assign down_valid = valid_reg;
    assign down_item  = item_reg;

endmodule

>>> rtl/gwwm_core.sv
// Running line, word and paragraph accumulators with the result register.
`timescale 1ns / 1ps

module gwwm_core
    import gwwm_pkg::*;
#(
    parameter int ACC_BITS  = ACC_BITS_DEFAULT,
    parameter int LINE_BITS = LINE_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [WIDTH_BITS-1:0] wrap_limit,
    input  logic [SPACE_BITS-1:0] space_advance,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  res_valid,
    input  logic                  res_ready,
    output result_t               res
);

    // Wide enough for any sum of two accumulators and for the 31-bit limit.
    localparam int EXT = (ACC_BITS + 2 > 34) ? ACC_BITS + 2 : 34;
    localparam int LW  = (LINE_BITS > COUNT_BITS) ? LINE_BITS : COUNT_BITS;

    typedef logic signed [EXT-1:0]      ext_t;
    typedef logic signed [ACC_BITS-1:0] acc_t;
    typedef logic [LINE_BITS-1:0]       lines_t;

    localparam logic [EXT-1:0] ACC_MAX_U = {{(EXT-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
    localparam ext_t           ACC_MAX_E = signed'(ACC_MAX_U);
    localparam lines_t         LINES_ONE = lines_t'(1);

    function automatic acc_t sat_acc(ext_t v);
        ext_t r;
        r = v;
        if (v > ACC_MAX_E)
        begin
            r = ACC_MAX_E;
        end
        else if (v < -ACC_MAX_E)
        begin
            r = -ACC_MAX_E;
        end
        return r[ACC_BITS-1:0];
    endfunction

    function automatic ext_t max_e(ext_t a, ext_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic lines_t bump(lines_t x);
        return (&x) ? x : x + LINES_ONE;
    endfunction

    acc_t    line_reg, line_next;
    acc_t    visible_reg, visible_next;
    acc_t    word_reg, word_next;
    acc_t    widest_reg, widest_next;
    logic    in_run_reg, in_run_next;
    lines_t  lines_reg, lines_next;
    logic    res_valid_reg, res_valid_next;
    result_t res_reg, res_next;

    logic    wrapping;
    logic    is_end;
    logic    take;
    logic    take_end;
    ext_t    limit_e;
    ext_t    space_e;
    ext_t    kern_term;
    acc_t    word_add;

    // Word close at a separator or the end of text in wrap mode.
    ext_t    cw_w;
    ext_t    cw_sum;
    logic    cw_break;
    acc_t    cw_line;
    acc_t    cw_visible;
    acc_t    cw_widest;
    lines_t  cw_lines;
    acc_t    nl_widest;
    acc_t    sp_line;

    ext_t             width_raw;
    ext_t             width_clamped;
    lines_t           lines_out;
    logic [LW-1:0]    lines_wide;

    assign wrapping = (wrap_limit != '0);
    assign is_end   = (item.mode == MODE_END);
    assign item_ready = !is_end || !res_valid_reg || res_ready;
    assign take     = item_valid && item_ready;
    assign take_end = take && is_end;

    assign limit_e   = ext_t'(wrap_limit);
    assign space_e   = ext_t'(space_advance);
    assign kern_term = in_run_reg ? ext_t'(item.kern_adjust) : '0;
    assign word_add  = sat_acc(ext_t'(word_reg) + kern_term + ext_t'(item.advance));

    always_comb
    begin
        cw_w     = ext_t'(word_reg);
        cw_sum   = ext_t'(line_reg) + cw_w;
        cw_break = (cw_w > 0) && (cw_sum > limit_e) && (line_reg > 0);
        if (cw_break)
        begin
            cw_line    = word_reg;
            cw_visible = word_reg;
            cw_widest  = sat_acc(max_e(ext_t'(widest_reg), ext_t'(visible_reg)));
            cw_lines   = bump(lines_reg);
        end
        else
        begin
            cw_line    = sat_acc(cw_sum);
            cw_visible = (cw_w > 0) ? sat_acc(cw_sum) : visible_reg;
            cw_widest  = widest_reg;
            cw_lines   = lines_reg;
        end
        nl_widest = sat_acc(max_e(ext_t'(cw_widest), ext_t'(cw_visible)));
        sp_line   = sat_acc(ext_t'(cw_line) + space_e);
    end

    // Result of an end word: widest line or paragraph, clamped.
    always_comb
    begin
        if (wrapping)
        begin
            width_raw = max_e(ext_t'(cw_widest), ext_t'(cw_line));
            if (width_raw > limit_e)
            begin
                width_raw = limit_e;
            end
            lines_out = cw_lines;
        end
        else
        begin
            width_raw = max_e(ext_t'(widest_reg), ext_t'(word_reg));
            lines_out = lines_reg;
        end
        width_clamped = width_raw;
        if (width_raw < 0)
        begin
            width_clamped = '0;
        end
        else if (width_raw > ext_t'(WIDTH_MAX))
        begin
            width_clamped = ext_t'(WIDTH_MAX);
        end
        lines_wide = LW'(lines_out);
        if (lines_wide > LW'(COUNT_MAX))
        begin
            lines_wide = LW'(COUNT_MAX);
        end
        res_next.text_width = width_clamped[WIDTH_BITS-1:0];
        res_next.line_count = lines_wide[COUNT_BITS-1:0];
    end

    always_comb
    begin
        line_next    = line_reg;
        visible_next = visible_reg;
        word_next    = word_reg;
        widest_next  = widest_reg;
        in_run_next  = in_run_reg;
        lines_next   = lines_reg;
        if (take)
        begin
            if (is_end)
            begin
                line_next    = '0;
                visible_next = '0;
                word_next    = '0;
                widest_next  = '0;
                in_run_next  = 1'b0;
                lines_next   = LINES_ONE;
            end
            else if (!wrapping)
            begin
                // Paragraph mode: spaces and tabs measure like glyphs.
                if (item.char_class == CLASS_NEWLINE)
                begin
                    widest_next = sat_acc(max_e(ext_t'(widest_reg), ext_t'(word_reg)));
                    lines_next  = bump(lines_reg);
                    word_next   = '0;
                    in_run_next = 1'b0;
                end
                else
                begin
                    word_next   = word_add;
                    in_run_next = 1'b1;
                end
            end
            else
            begin
                case (item.char_class) inside
                    CLASS_GLYPH:
                    begin
                        word_next   = word_add;
                        in_run_next = 1'b1;
                    end
                    CLASS_SPACE, CLASS_TAB:
                    begin
                        line_next    = sp_line;
                        visible_next = cw_visible;
                        widest_next  = cw_widest;
                        lines_next   = cw_lines;
                        word_next    = '0;
                        in_run_next  = 1'b0;
                    end
                    default:
                    begin
                        line_next    = '0;
                        visible_next = '0;
                        widest_next  = nl_widest;
                        lines_next   = bump(cw_lines);
                        word_next    = '0;
                        in_run_next  = 1'b0;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (take_end)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg      <= '0;
            visible_reg   <= '0;
            word_reg      <= '0;
            widest_reg    <= '0;
            in_run_reg    <= 1'b0;
            lines_reg     <= LINES_ONE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            line_reg      <= line_next;
            visible_reg   <= visible_next;
            word_reg      <= word_next;
            widest_reg    <= widest_next;
            in_run_reg    <= in_run_next;
            lines_reg     <= lines_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_end)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // The line counter starts at one and saturates, so it never reads zero.
    a_lines_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lines_reg != '0)
        else $error("line counter reached zero");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take_end |=> (word_reg == '0) && (line_reg == '0) && (visible_reg == '0)
                     && (widest_reg == '0) && !in_run_reg && (lines_reg == LINES_ONE))
        else $error("state not cleared after end word");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(take_end))
        else $error("result appeared without an end word");

    a_width_limited: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(take_end) && ($past(wrap_limit) != '0))
            |-> (res_reg.text_width <= $past(wrap_limit)))
        else $error("wrapped width exceeds the limit");

endmodule

>>> rtl/greedy_word_wrap_measurer.sv
// Top level of the greedy word wrap measurer: configuration registers and channels.
//
//  channel  signals                                      direction  fires on
//  in       in_valid/in_ready, mode, char_class,         into       in_valid && in_ready
//           advance, kern_adjust
//  out      out_valid/out_ready, text_width, line_count  out of     out_valid && out_ready
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data     into       cfg_valid && cfg_ready
//
// One word is accepted per cycle unless a waiting result stalls the input; each word
// passes an input register and then the accumulator update, which loads the result
// register at the next edge.
// The accumulator update is combinational and sets the rate of one word per cycle.
// Reset clears the accumulators, sets the line count to one and the configuration registers to zero.
// A result waiting in the output register holds a following end word in the input
// register, and that in turn stalls the input.
// Configuration writes are always taken.
`timescale 1ns / 1ps

module greedy_word_wrap_measurer
    import gwwm_pkg::*;
#(
    parameter int ACC_BITS  = ACC_BITS_DEFAULT,
    parameter int LINE_BITS = LINE_BITS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        mode,
    input  logic [1:0]                  char_class,
    input  logic [ADV_BITS-1:0]         advance,
    input  logic signed [KERN_BITS-1:0] kern_adjust,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [WIDTH_BITS-1:0]       text_width,
    output logic [COUNT_BITS-1:0]       line_count,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_data
);

    logic [WIDTH_BITS-1:0] wrap_limit_reg, wrap_limit_next;
    logic [SPACE_BITS-1:0] space_advance_reg, space_advance_next;

    item_t   up_item;
    item_t   stage_item;
    logic    stage_valid;
    logic    stage_ready;
    result_t res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        wrap_limit_next    = wrap_limit_reg;
        space_advance_next = space_advance_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WRAP_LIMIT:    wrap_limit_next    = cfg_data[WIDTH_BITS-1:0];
                CFG_SPACE_ADVANCE: space_advance_next = cfg_data[SPACE_BITS-1:0];
                default:
                begin
                    wrap_limit_next    = wrap_limit_reg;
                    space_advance_next = space_advance_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_limit_reg    <= '0;
            space_advance_reg <= '0;
        end
        else
        begin
            wrap_limit_reg    <= wrap_limit_next;
            space_advance_reg <= space_advance_next;
        end
    end

    assign up_item.mode        = mode;
    assign up_item.char_class  = char_class;
    assign up_item.advance     = advance;
    assign up_item.kern_adjust = kern_adjust;

    gwwm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (in_valid),
        .up_ready   (in_ready),
        .up_item    (up_item),
        .down_valid (stage_valid),
        .down_ready (stage_ready),
        .down_item  (stage_item)
    );

    gwwm_core #(
        .ACC_BITS  (ACC_BITS),
        .LINE_BITS (LINE_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .wrap_limit    (wrap_limit_reg),
        .space_advance (space_advance_reg),
        .item_valid    (stage_valid),
        .item_ready    (stage_ready),
        .item          (stage_item),
        .res_valid     (out_valid),
        .res_ready     (out_ready),
        .res           (res)
    );

    assign text_width = res.text_width;
    assign line_count = res.line_count;

endmodule
